// File: src/cbfe_pkg.sv
// Shared types and constants for the complemented byte frame encoder.
package cbfe_pkg;

	// Item kinds on the func field
	localparam logic FUNC_CMD   = 1'b0;
	localparam logic FUNC_PARAM = 1'b1;

	// Frame preamble bytes
	localparam logic [7:0] PREAMBLE_0 = 8'h55;
	localparam logic [7:0] PREAMBLE_1 = 8'hFF;
	localparam logic [7:0] PREAMBLE_2 = 8'h00;

	// Position of a result within the bytes one item expands to
	typedef logic [2:0] step_t;
	localparam step_t STEP_PRE0   = 3'd0;
	localparam step_t STEP_PRE1   = 3'd1;
	localparam step_t STEP_PRE2   = 3'd2;
	localparam step_t STEP_DATA   = 3'd3;
	localparam step_t STEP_DATA_N = 3'd4;
	localparam step_t STEP_SUM    = 3'd5;
	localparam step_t STEP_SUM_N  = 3'd6;

	// One result item
	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       frame_end;
		logic       error;
	} result_t;

endpackage

// File: src/cbfe_if.sv
// Valid/ready channel interfaces for command items and encoded bytes.
interface cbfe_in_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic [7:0] data_byte;
	logic       last;

	modport source (output valid, func, data_byte, last, input ready);
	modport sink (input valid, func, data_byte, last, output ready);
endinterface

interface cbfe_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       frame_end;
	logic       error;

	modport source (output valid, out_byte, run_last, frame_end, error, input ready);
	modport sink (input valid, out_byte, run_last, frame_end, error, output ready);
endinterface

// File: src/cbfe_gen.sv
// Item register, frame state and byte sequencer of the frame encoder.
module cbfe_gen (
	input  logic                   clk,
	input  logic                   arst_n,
	cbfe_in_if.sink                cmd,
	output cbfe_pkg::result_t      res,
	output logic                   res_valid,
	input  logic                   res_ready
);

	logic              busy_s1;
	cbfe_pkg::step_t   step_s1;
	logic              err_s1;
	logic              last_s1;
	logic [7:0]        byte_s1;
	logic [7:0]        sum_s1;

	logic [7:0]        run_sum_q;
	logic              open_q;

	logic              final_step;
	logic              advance;
	logic              accept;
	logic              err_in;
	logic [7:0]        sum_in;

	assign final_step = err_s1 ||
		(step_s1 == (last_s1 ? cbfe_pkg::STEP_SUM_N : cbfe_pkg::STEP_DATA_N));
	assign advance    = busy_s1 && res_ready;
	assign cmd.ready  = !busy_s1 || (res_ready && final_step);
	assign accept     = cmd.valid && cmd.ready;

	assign err_in = (cmd.func == cbfe_pkg::FUNC_PARAM) && !open_q;
	// A command restarts the sum
	assign sum_in = ((cmd.func == cbfe_pkg::FUNC_CMD) ? 8'h00 : run_sum_q) + cmd.data_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1   <= 1'b0;
			step_s1   <= cbfe_pkg::STEP_PRE0;
			run_sum_q <= 8'h00;
			open_q    <= 1'b0;
		end else if (accept) begin
			busy_s1 <= 1'b1;
			step_s1 <= (cmd.func == cbfe_pkg::FUNC_CMD) ? cbfe_pkg::STEP_PRE0
			                                             : cbfe_pkg::STEP_DATA;
			if (!err_in) begin
				run_sum_q <= sum_in;
				open_q    <= !cmd.last;
			end
		end else if (advance) begin
			if (final_step) begin
				busy_s1 <= 1'b0;
			end else begin
				step_s1 <= cbfe_pkg::step_t'(step_s1 + 3'd1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			err_s1  <= err_in;
			last_s1 <= cmd.last;
			byte_s1 <= cmd.data_byte;
			sum_s1  <= sum_in;
		end
	end

	always_comb begin
		res           = '0;
		res.run_last  = final_step;
		case (step_s1)
			cbfe_pkg::STEP_PRE0:   res.out_byte = cbfe_pkg::PREAMBLE_0;
			cbfe_pkg::STEP_PRE1:   res.out_byte = cbfe_pkg::PREAMBLE_1;
			cbfe_pkg::STEP_PRE2:   res.out_byte = cbfe_pkg::PREAMBLE_2;
			cbfe_pkg::STEP_DATA:   res.out_byte = byte_s1;
			cbfe_pkg::STEP_DATA_N: res.out_byte = ~byte_s1;
			cbfe_pkg::STEP_SUM:    res.out_byte = sum_s1;
			cbfe_pkg::STEP_SUM_N: begin
				res.out_byte  = ~sum_s1;
				res.frame_end = 1'b1;
			end
			default:               res.out_byte = 8'h00;
		endcase
		if (err_s1) begin
			res.out_byte  = 8'h00;
			res.frame_end = 1'b0;
			res.error     = 1'b1;
		end
	end

	assign res_valid = busy_s1;

endmodule

// File: src/cbfe_out_reg.sv
// Output register stage driving the encoded byte channel.
module cbfe_out_reg (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cbfe_pkg::result_t      res,
	input  logic                   res_valid,
	output logic                   res_ready,
	cbfe_out_if.source             tx
);

	logic              valid_q;
	cbfe_pkg::result_t data_q;

	assign res_ready = !valid_q || tx.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_ready) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			data_q <= res;
		end
	end

	assign tx.valid     = valid_q;
	assign tx.out_byte  = data_q.out_byte;
	assign tx.run_last  = data_q.run_last;
	assign tx.frame_end = data_q.frame_end;
	assign tx.error     = data_q.error;

endmodule

// File: src/complemented_byte_frame_encoder.sv
// Top level of the complemented byte frame encoder.
//
//   channel  dir  handshake      payload
//   cmd      in   valid/ready    func, data_byte, last
//   tx       out  valid/ready    out_byte, run_last, frame_end, error
//
// One item expands to 2, 4, 5 or 7 bytes (1 for an orphan parameter);
// the byte sequencer emits one byte per cycle while the output register
// accepts, so an item holds the sequencer until its final byte is taken.
// The next item is taken in the cycle the current item's final byte moves
// into the output register, so items follow with no gap.
// Reset clears the running sum, frame-open flag and both valid flags.
// A stall on tx holds the output register and then the sequencer; cmd
// waits once the sequencer holds an item whose bytes are not all out.
module complemented_byte_frame_encoder (
	input  logic       clk,
	input  logic       arst_n,
	cbfe_in_if.sink    cmd,
	cbfe_out_if.source tx
);

	cbfe_pkg::result_t res;
	logic              res_valid;
	logic              res_ready;

	// Frame state and byte-by-byte expansion of each item
	cbfe_gen u_gen (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.res       (res),
		.res_valid (res_valid),
		.res_ready (res_ready)
	);

	// Registered output; decouples the sequencer from tx back-pressure
	cbfe_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res       (res),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.tx        (tx)
	);

endmodule

// File: tb/cbfe_frame_checker.sv
`timescale 1ns / 1ps
// Checker that predicts the encoded byte stream of the frame encoder and compares the tx channel.
module cbfe_frame_checker (
	input  logic clk,
	input  logic arst_n,
	cbfe_in_if   cmd,
	cbfe_out_if  tx,
	output int   fails,
	output int   pending
);

	cbfe_pkg::result_t expected_bytes[$];
	logic [7:0]        frame_sum;
	logic              frame_active;

	// Expands one accepted item into the bytes it must produce, updating the frame state.
	task automatic encode_item(input logic f, input logic [7:0] b, input logic l);
		logic [7:0]        wire_bytes[$];
		logic              closes[$];
		logic [7:0]        sum;
		cbfe_pkg::result_t r;
		if (f == cbfe_pkg::FUNC_PARAM && !frame_active) begin
			// orphan parameter: single error item, state untouched
			r.out_byte  = 8'h00;
			r.run_last  = 1'b1;
			r.frame_end = 1'b0;
			r.error     = 1'b1;
			expected_bytes.push_back(r);
		end else begin
			sum = frame_sum;
			if (f == cbfe_pkg::FUNC_CMD) begin
				// a command always restarts the frame, abandoning any open one
				wire_bytes.push_back(cbfe_pkg::PREAMBLE_0); closes.push_back(1'b0);
				wire_bytes.push_back(cbfe_pkg::PREAMBLE_1); closes.push_back(1'b0);
				wire_bytes.push_back(cbfe_pkg::PREAMBLE_2); closes.push_back(1'b0);
				sum          = 8'h00;
				frame_active = 1'b1;
			end
			wire_bytes.push_back(b);  closes.push_back(1'b0);
			wire_bytes.push_back(~b); closes.push_back(1'b0);
			sum = sum + b;
			if (l) begin
				wire_bytes.push_back(sum);  closes.push_back(1'b0);
				wire_bytes.push_back(~sum); closes.push_back(1'b1);
				frame_active = 1'b0;
			end
			frame_sum = sum;
			for (int i = 0; i < wire_bytes.size(); i++) begin
				r.out_byte  = wire_bytes[i];
				r.run_last  = (i == wire_bytes.size() - 1);
				r.frame_end = closes[i];
				r.error     = 1'b0;
				expected_bytes.push_back(r);
			end
		end
	endtask

	function automatic int field_diff(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		cbfe_pkg::result_t want;
		if (!arst_n) begin
			expected_bytes.delete();
			frame_sum    = 8'h00;
			frame_active = 1'b0;
			pending      = 0;
		end else begin
			if (cmd.valid && cmd.ready)
				encode_item(cmd.func, cmd.data_byte, cmd.last);
			if (tx.valid && tx.ready) begin
				if (expected_bytes.size() == 0) begin
					$display("%0t: unexpected item, expected none, actual byte %02h err %0b",
						$time, tx.out_byte, tx.error);
					fails = fails + 1;
				end else begin
					want  = expected_bytes.pop_front();
					fails = fails + field_diff("out_byte", want.out_byte, tx.out_byte)
						+ field_diff("run_last", want.run_last, tx.run_last)
						+ field_diff("frame_end", want.frame_end, tx.frame_end)
						+ field_diff("error", want.error, tx.error);
				end
			end
			pending = expected_bytes.size();
		end
	end

endmodule

// File: tb/complemented_byte_frame_encoder_test.sv
`timescale 1ns / 1ps
// Top of the frame encoder testbench: clock, reset, stimulus, receiver and verdict.
module complemented_byte_frame_encoder_test;

	localparam int N_RANDOM    = 132;  // random items after the directed part
	localparam int HOLD_CYCLES = 80;   // long receiver hold-off, fills the block
	localparam int DRAIN_WAIT  = 20;   // cycles after the last expected byte

	logic clk;
	logic arst_n;
	int   fails;
	int   pending;
	int   sent;      // accepted input items so far
	bit   quiet;     // when set, neither side idles
	int   hold_req;  // bumped by the stimulus to ask for a long hold-off

	cbfe_in_if  cmd_ch();
	cbfe_out_if tx_ch();

	complemented_byte_frame_encoder u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.tx     (tx_ch)
	);

	cbfe_frame_checker u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch),
		.tx      (tx_ch),
		.fails   (fails),
		.pending (pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Idles with a chance of 18 in a hundred, never during a quiet stretch.
	function automatic bit idle_draw();
		return !quiet && ($urandom_range(0, 99) < 18);
	endfunction

	// Offer one item from a falling edge and hold it until the block takes it.
	// valid is only written once per negedge, so back-to-back items never glitch.
	task automatic send_item(input logic f, input logic [7:0] b, input logic l);
		@(negedge clk);
		while (idle_draw()) begin
			cmd_ch.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid     <= 1'b1;
		cmd_ch.func      <= f;
		cmd_ch.data_byte <= b;
		cmd_ch.last      <= l;
		do @(posedge clk); while (!cmd_ch.ready);
		sent++;
	endtask

	// A command followed by n_params parameters; closed puts last on the final item.
	task automatic send_frame(input int n_params, input bit closed);
		send_item(cbfe_pkg::FUNC_CMD, 8'($urandom()), closed && n_params == 0);
		for (int i = 0; i < n_params; i++)
			send_item(cbfe_pkg::FUNC_PARAM, 8'($urandom()), closed && i == n_params - 1);
	endtask

	// Receiver: random back-pressure, plus one long hold-off on request.
	initial begin
		int hold_left;
		int hold_seen;
		hold_left   = 0;
		hold_seen   = 0;
		tx_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				tx_ch.ready <= 1'b0;
				hold_left--;
			end else if (hold_seen != hold_req) begin
				hold_seen   = hold_req;
				hold_left   = HOLD_CYCLES - 1;
				tx_ch.ready <= 1'b0;
			end else begin
				tx_ch.ready <= !idle_draw();
			end
		end
	end

	// Hard stop in case the block hangs.
	initial begin
		#2_000_000;
		$display("complemented_byte_frame_encoder regression: fail");
		$finish;
	end

	initial begin
		int pick;
		bit hold_done;
		cmd_ch.valid     = 1'b0;
		cmd_ch.func      = cbfe_pkg::FUNC_CMD;
		cmd_ch.data_byte = 8'h00;
		cmd_ch.last      = 1'b0;
		arst_n           = 1'b0;
		quiet            = 1'b0;
		hold_req         = 0;
		sent             = 0;
		hold_done        = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part
		send_item(cbfe_pkg::FUNC_PARAM, 8'hAB, 1'b0);  // parameter before any frame: error
		send_item(cbfe_pkg::FUNC_PARAM, 8'h00, 1'b1);  // orphan with last set: still an error
		send_item(cbfe_pkg::FUNC_CMD,   8'h00, 1'b0);
		send_item(cbfe_pkg::FUNC_PARAM, 8'hFF, 1'b1);  // min and max bytes, frame closes
		send_item(cbfe_pkg::FUNC_CMD,   8'hFF, 1'b1);  // open and close in one item
		send_item(cbfe_pkg::FUNC_CMD,   8'h00, 1'b1);
		send_item(cbfe_pkg::FUNC_CMD,   8'h12, 1'b0);
		send_item(cbfe_pkg::FUNC_PARAM, 8'h80, 1'b0);
		send_item(cbfe_pkg::FUNC_CMD,   8'h34, 1'b0);  // new command abandons the open frame
		send_item(cbfe_pkg::FUNC_PARAM, 8'h01, 1'b0);
		send_item(cbfe_pkg::FUNC_PARAM, 8'hFE, 1'b1);
		send_item(cbfe_pkg::FUNC_PARAM, 8'h5A, 1'b1);  // frame closed again: error
		send_item(cbfe_pkg::FUNC_CMD,   8'hF0, 1'b0);  // sum wraps past 255
		send_item(cbfe_pkg::FUNC_PARAM, 8'hF0, 1'b0);
		send_item(cbfe_pkg::FUNC_PARAM, 8'hF0, 1'b1);
		send_item(cbfe_pkg::FUNC_CMD,   8'hAA, 1'b0);
		send_item(cbfe_pkg::FUNC_PARAM, 8'h55, 1'b0);
		send_item(cbfe_pkg::FUNC_PARAM, 8'h7F, 1'b1);

		// Random part: mostly complete frames, some left open, some noise
		while (sent < 18 + N_RANDOM) begin
			if (!hold_done && sent >= 60) begin
				hold_req++;
				hold_done = 1'b1;
			end
			quiet = (sent >= 100 && sent < 130);
			pick  = $urandom_range(0, 99);
			if (pick < 75)
				send_frame($urandom_range(0, 6), 1'b1);
			else if (pick < 85)
				send_frame($urandom_range(0, 3), 1'b0);
			else
				send_item(1'($urandom()), 8'($urandom()), 1'($urandom()));
		end
		quiet = 1'b0;
		@(negedge clk);
		cmd_ch.valid <= 1'b0;

		wait (pending == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("complemented_byte_frame_encoder regression: pass");
		else
			$display("complemented_byte_frame_encoder regression: fail");
		$finish;
	end

endmodule

// File: files.f
src/cbfe_pkg.sv
src/cbfe_if.sv
src/cbfe_gen.sv
src/cbfe_out_reg.sv
src/complemented_byte_frame_encoder.sv
tb/cbfe_frame_checker.sv
tb/complemented_byte_frame_encoder_test.sv
